[hw/rtl/assert_macros.svh]
// assertion macros used by the mrkm_checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, off while reset is held
`define MRKM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mrkm assertion failed");

// implication into the next cycle, off while reset is held
`define MRKM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mrkm assertion failed");

// what must hold in the cycle after a reset edge
`define MRKM_ASSERT_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("mrkm assertion failed");

`endif

[hw/rtl/mrkm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mrkm_pkg;

    localparam int KEY_COUNT = 12;
    localparam int KEY_MAX   = 10;
    localparam int WIN_DEPTH = 9;
    localparam int CODE_W    = 4;

    // command field of an input beat
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [CODE_W-1:0] CODE_NONE = '0;

    // keyword text, right aligned, zero padded on the left
    localparam logic [KEY_MAX*8-1:0] KEY_TEXT [KEY_COUNT] = '{
        "OK", "ERROR", "CONNECT", "NO CARRIER", "IP STATUS", "IP INITIAL",
        "SHUT OK", "CLOSED", "DEACT", "READY", ".", "POWER DOWN"
    };

    localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{
        4'd2, 4'd5, 4'd7, 4'd10, 4'd9, 4'd10, 4'd7, 4'd6, 4'd5, 4'd5, 4'd1, 4'd10
    };

    // one queued beat after classification
    typedef struct packed {
        logic       is_query;
        logic [7:0] ch;
    } t_item;

    // newest byte at index 0
    typedef logic [WIN_DEPTH-1:0][7:0] t_window;

    // which keywords the window ends with, current byte included
    function automatic logic [KEY_COUNT-1:0] match_keys(input logic [7:0] cur,
                                                        input t_window win);
        logic [KEY_MAX-1:0][7:0] full;
        logic [KEY_COUNT-1:0]    hit;
        full = {win, cur};
        hit  = '1;
        for (int k = 0; k < KEY_COUNT; k++) begin
            for (int i = 0; i < KEY_MAX; i++) begin
                if ((i < int'(KEY_LEN[k])) && (full[i] != KEY_TEXT[k][8*i +: 8])) begin
                    hit[k] = 1'b0;
                end
            end
        end
        return hit;
    endfunction

    // highest set flag as a keyword number, zero when none
    function automatic logic [CODE_W-1:0] code_of(input logic [KEY_COUNT-1:0] hits);
        logic [CODE_W-1:0] code;
        code = CODE_NONE;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (hits[k]) begin
                code = CODE_W'(k + 1);
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/modem_response_keyword_matcher_top.sv]
// Modem response keyword matcher.
// Input channel (i_valid / o_stall, fields i_cmd, i_rx_byte): one beat is
// either a received byte (i_cmd = 0) or a query (i_cmd = 1). A beat is taken
// at a clock edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall, field o_response_code): one beat per
// query, carrying the highest keyword number matched since the last query
// (1 OK ... 12 POWER DOWN, 0 for none). Bytes produce no output beat.
// Throughput: one input beat per cycle, bytes and queries alike, while o_stall
// is low. Accepted beats go into a QUEUE_DEPTH entry queue; the matcher drains
// one beat per cycle unless a query at the head waits for the output register,
// its compare of the byte and the nine byte window finishing in that same cycle.
// When idle, a query passes its queue entry, then the output register for o_valid.
// Stall: while i_stall holds an answer, bytes drain until a query heads the queue;
// that query and later beats wait, and o_stall rises once the queue is full.
// Reset (i_rst_n low, synchronous): queue emptied, window, hit flags and end
// of string mark cleared, no output beat pending.
`timescale 1ns / 1ps
`default_nettype none

module modem_response_keyword_matcher_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_cmd,
    input  wire logic [7:0]                     i_rx_byte,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [mrkm_pkg::CODE_W-1:0]         o_response_code
);

    mrkm_pkg::t_item w_in_item;
    mrkm_pkg::t_item w_head;
    logic            w_push;
    logic            w_full;
    logic            w_head_valid;
    logic            w_pop;

    // classify incoming beats
    mrkm_front u_front (
        .i_valid   (i_valid),
        .i_cmd     (i_cmd),
        .i_rx_byte (i_rx_byte),
        .i_full    (w_full),
        .o_item    (w_in_item),
        .o_push    (w_push),
        .o_stall   (o_stall)
    );

    // queue between front and matcher
    mrkm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_item       (w_in_item),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .o_full       (w_full)
    );

    // window match and answer
    mrkm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_head_valid    (w_head_valid),
        .o_pop           (w_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_response_code (o_response_code)
    );

endmodule

`default_nettype wire

[hw/rtl/mrkm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrkm_front (
    input  wire logic           i_valid,
    input  wire logic           i_cmd,
    input  wire logic [7:0]     i_rx_byte,
    input  wire logic           i_full,
    output mrkm_pkg::t_item     o_item,
    output logic                o_push,
    output logic                o_stall
);

    logic [7:0] w_ch;

    // line ends read as a space
    always_comb begin
        if ((i_rx_byte == mrkm_pkg::CHAR_LF) || (i_rx_byte == mrkm_pkg::CHAR_CR)) begin
            w_ch = mrkm_pkg::CHAR_SPACE;
        end else begin
            w_ch = i_rx_byte;
        end
    end

    // a query carries no byte
    always_comb begin
        o_item.is_query = i_cmd;
        o_item.ch       = i_cmd ? mrkm_pkg::CHAR_NUL : w_ch;
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

`default_nettype wire

[hw/rtl/mrkm_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrkm_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mrkm_pkg::t_item i_item,
    input  wire logic            i_pop,
    output mrkm_pkg::t_item      o_head,
    output logic                 o_head_valid,
    output logic                 o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mrkm_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            w_push;
    logic            w_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign w_push       = i_push && !o_full;
    assign w_pop        = i_pop && o_head_valid;

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mrkm_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrkm_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mrkm_pkg::t_item                i_head,
    input  wire logic                           i_head_valid,
    output logic                                o_pop,
    input  wire logic                           i_stall,
    output logic                                o_valid,
    output logic [mrkm_pkg::CODE_W-1:0]         o_response_code
);

    mrkm_pkg::t_window                  r_win, n_win;
    logic [mrkm_pkg::KEY_COUNT-1:0]     r_hits, n_hits;
    logic                               r_ended, n_ended;
    logic                               r_out_valid, n_out_valid;
    logic [mrkm_pkg::CODE_W-1:0]        r_code, n_code;
    logic [mrkm_pkg::KEY_COUNT-1:0]     w_match;
    logic                               w_nul;

    // a query waits for room in the output register, a byte never waits
    assign o_pop = i_head_valid && (!i_head.is_query || !r_out_valid || !i_stall);

    assign w_match = mrkm_pkg::match_keys(i_head.ch, r_win);
    assign w_nul   = (i_head.ch == mrkm_pkg::CHAR_NUL);

    // window, flags and output register
    always_comb begin
        n_win       = r_win;
        n_hits      = r_hits;
        n_ended     = r_ended;
        n_code      = r_code;
        n_out_valid = r_out_valid && i_stall;
        if (o_pop) begin
            if (i_head.is_query) begin
                n_out_valid = 1'b1;
                n_code      = mrkm_pkg::code_of(r_hits);
                n_win       = '0;
                n_hits      = '0;
                n_ended     = 1'b0;
            end else begin
                if (!r_ended && !w_nul) begin
                    n_hits = r_hits | w_match;
                end
                if (w_nul) begin
                    n_ended = 1'b1;
                end
                n_win = {r_win[mrkm_pkg::WIN_DEPTH-2:0], i_head.ch};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_hits      <= '0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_win       <= n_win;
            r_hits      <= n_hits;
            r_ended     <= n_ended;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_valid         = r_out_valid;
    assign o_response_code = r_code;

endmodule

`default_nettype wire

[hw/rtl/mrkm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mrkm_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire logic                           o_stall,
    input  wire logic                           i_cmd,
    input  wire logic [7:0]                     i_rx_byte,
    input  wire logic                           o_valid,
    input  wire logic                           i_stall,
    input  wire logic [mrkm_pkg::CODE_W-1:0]    o_response_code
);

    logic [8:0] w_in_beat;
    assign w_in_beat = {i_cmd, i_rx_byte};

    // answer is a keyword number or zero
    `MRKM_ASSERT_SAME(a_code_range, i_clk, i_rst_n, o_valid, o_response_code <= 4'd12)
    // a held answer stays put
    `MRKM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_response_code))
    // a stalled input beat stays put
    `MRKM_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(w_in_beat))
    // reset leaves no answer pending
    `MRKM_ASSERT_RESET(a_rst_no_out, i_clk, i_rst_n, !o_valid)
    // reset empties the queue
    `MRKM_ASSERT_RESET(a_rst_ready, i_clk, i_rst_n, !o_stall)

endmodule

bind modem_response_keyword_matcher_top mrkm_checker u_mrkm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_cmd           (i_cmd),
    .i_rx_byte       (i_rx_byte),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_response_code (o_response_code)
);

`default_nettype wire

[sim/keyword_match_checker.sv]
`timescale 1ns / 1ps

module keyword_match_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_cmd,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [mrkm_pkg::CODE_W-1:0] i_response_code,
    output int                          o_fail_count,
    output int                          o_codes_pending
);

    localparam int   WINDOW_BYTES  = 9;
    localparam int   KEYWORD_COUNT = 12;

    // keyword k+1 is entry k
    string keyword_list [KEYWORD_COUNT] = '{
        "OK", "ERROR", "CONNECT", "NO CARRIER", "IP STATUS", "IP INITIAL",
        "SHUT OK", "CLOSED", "DEACT", "READY", ".", "POWER DOWN"
    };

    // predicted matcher state, newest byte at index 0
    logic [7:0]               recent_bytes [WINDOW_BYTES];
    logic [KEYWORD_COUNT-1:0] seen_keywords;
    logic                     text_ended;

    // answers owed for accepted queries, oldest first
    logic [mrkm_pkg::CODE_W-1:0] owed_codes [$];

    function automatic bit window_ends_with(input logic [7:0] newest, input string word);
        int         n;
        logic [7:0] have;
        bit         hit;
        n   = word.len();
        hit = 1'b1;
        for (int i = 0; i < n; i++) begin
            have = (i == 0) ? newest : recent_bytes[i-1];
            if (have != 8'(word[n-1-i])) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    // highest keyword number seen, none gives zero
    function automatic logic [mrkm_pkg::CODE_W-1:0] strongest_keyword();
        logic [mrkm_pkg::CODE_W-1:0] code;
        code = mrkm_pkg::CODE_NONE;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            if (seen_keywords[k]) begin
                code = mrkm_pkg::CODE_W'(k + 1);
            end
        end
        return code;
    endfunction

    task automatic clear_history();
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            recent_bytes[i] = mrkm_pkg::CHAR_NUL;
        end
        seen_keywords = '0;
        text_ended    = 1'b0;
    endtask

    // line endings read as spaces, a nul byte stops matching until the next query
    task automatic take_byte(input logic [7:0] raw);
        logic [7:0] ch;
        ch = (raw == mrkm_pkg::CHAR_LF || raw == mrkm_pkg::CHAR_CR) ?
             mrkm_pkg::CHAR_SPACE : raw;
        if (ch == mrkm_pkg::CHAR_NUL) begin
            text_ended = 1'b1;
        end
        if (!text_ended) begin
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                if (window_ends_with(ch, keyword_list[k])) begin
                    seen_keywords[k] = 1'b1;
                end
            end
        end
        for (int i = WINDOW_BYTES - 1; i > 0; i--) begin
            recent_bytes[i] = recent_bytes[i-1];
        end
        recent_bytes[0] = ch;
    endtask

    // compare answer beats first, then fold in the input beat of the same edge
    always @(posedge i_clk) begin
        logic [mrkm_pkg::CODE_W-1:0] want;
        if (!i_rst_n) begin
            clear_history();
            owed_codes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_codes.size() == 0) begin
                    $error("response_code beat with no query waiting: expected none, actual %0d",
                           i_response_code);
                    o_fail_count++;
                end else begin
                    want = owed_codes.pop_front();
                    if (i_response_code !== want) begin
                        $error("response_code mismatch: expected %0d, actual %0d",
                               want, i_response_code);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_cmd == mrkm_pkg::CMD_QUERY) begin
                    owed_codes.push_back(strongest_keyword());
                    clear_history();
                end else begin
                    take_byte(i_rx_byte);
                end
            end
        end
        o_codes_pending = owed_codes.size();
    end

endmodule

[sim/modem_response_keyword_matcher_top_test.sv]
`timescale 1ns / 1ps

module modem_response_keyword_matcher_top_test;

    localparam int   ITEM_TARGET   = 2000;
    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   DRAIN_CYCLES  = 20;

    // keyword positions in the package table
    localparam int   KW_OK         = 0;
    localparam int   KW_DOT        = 10;
    localparam int   KW_POWER_DOWN = 11;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic                        i_cmd;
    logic [7:0]                  i_rx_byte;
    logic                        o_valid;
    logic                        i_stall;
    logic [mrkm_pkg::CODE_W-1:0] o_response_code;

    int fail_count;
    int codes_pending;
    int cycle_count;
    int items_sent;
    bit sender_calm;
    bit hold_request;
    bit hold_active;

    modem_response_keyword_matcher_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_response_code (o_response_code)
    );

    keyword_match_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_cmd           (i_cmd),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_response_code (o_response_code),
        .o_fail_count    (fail_count),
        .o_codes_pending (codes_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run time guard
    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("modem_response_keyword_matcher_top_test failed");
        $finish;
    end

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_calm || r < 70) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // one input beat, held until taken, then an optional gap
    task automatic send_beat(input logic cmd, input logic [7:0] data);
        int gap;
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_rx_byte <= data;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_beat(mrkm_pkg::CMD_BYTE, data);
    endtask

    // byte field carries junk on a query
    task automatic send_query();
        send_beat(mrkm_pkg::CMD_QUERY, 8'($urandom_range(0, 255)));
    endtask

    // first keep characters of a keyword, spaces optionally sent as line endings
    task automatic send_keyword(input int k, input int keep, input bit swap_spaces);
        int         len;
        logic [7:0] ch;
        len = int'(mrkm_pkg::KEY_LEN[k]);
        for (int j = 0; j < keep; j++) begin
            ch = mrkm_pkg::KEY_TEXT[k][8*(len-1-j) +: 8];
            if (swap_spaces && ch == mrkm_pkg::CHAR_SPACE && $urandom_range(0, 1) == 1) begin
                ch = ($urandom_range(0, 1) == 1) ? mrkm_pkg::CHAR_CR : mrkm_pkg::CHAR_LF;
            end
            send_byte(ch);
        end
    endtask

    task automatic send_line_end();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) begin
            send_byte(mrkm_pkg::CHAR_CR);
            send_byte(mrkm_pkg::CHAR_LF);
        end else if (r == 1) begin
            send_byte(mrkm_pkg::CHAR_LF);
        end else begin
            send_byte(mrkm_pkg::CHAR_SPACE);
        end
    endtask

    // a modem response line with a little leading text
    task automatic send_response(input int k);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
        send_keyword(k, int'(mrkm_pkg::KEY_LEN[k]), 1'b1);
        send_line_end();
    endtask

    // answer side: random stalls, calm stretches, one long hold on request
    initial begin
        bit calm;
        bit hold_done;
        int n;
        i_stall     = 1'b0;
        hold_active = 1'b0;
        calm        = 1'b0;
        hold_done   = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                calm = !calm;
            end
            if (hold_request && !hold_done) begin
                i_stall     <= 1'b1;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done   = 1'b1;
                hold_active = 1'b0;
            end else begin
                n = $urandom_range(0, 99);
                if (calm || n < 60) begin
                    n = 0;
                end else if (n < 92) begin
                    n = $urandom_range(1, 3);
                end else begin
                    n = $urandom_range(10, 40);
                end
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(negedge i_clk);
                end
            end
            i_stall <= 1'b0;
            repeat (calm ? $urandom_range(20, 60) : $urandom_range(1, 4)) @(negedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin
        int r;
        bit pressure_done;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cmd         = mrkm_pkg::CMD_BYTE;
        i_rx_byte     = 8'h00;
        items_sent    = 0;
        sender_calm   = 1'b0;
        hold_request  = 1'b0;
        pressure_done = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // nothing heard since reset
        send_query();
        // top byte value, line endings around the dot
        send_byte(8'hFF);
        send_byte(mrkm_pkg::CHAR_CR);
        send_keyword(KW_DOT, 1, 1'b0);
        send_byte(mrkm_pkg::CHAR_LF);
        send_query();
        // keyword at an empty window, then a nul blocks the dot
        send_keyword(KW_OK, 2, 1'b0);
        send_byte(mrkm_pkg::CHAR_NUL);
        send_keyword(KW_DOT, 1, 1'b0);
        send_query();
        // longest keyword fills the whole window, then a cleared query
        send_keyword(KW_POWER_DOWN, int'(mrkm_pkg::KEY_LEN[KW_POWER_DOWN]), 1'b0);
        send_query();
        send_query();

        // mostly response lines, some broken lines, noise and nul bytes
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                sender_calm = !sender_calm;
            end
            if (!pressure_done && items_sent > ITEM_TARGET / 3) begin
                // answers held off while queries keep coming
                pressure_done = 1'b1;
                hold_request  = 1'b1;
                wait (hold_active);
                repeat (12) begin
                    send_response($urandom_range(0, mrkm_pkg::KEY_COUNT - 1));
                    send_query();
                end
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_response($urandom_range(0, mrkm_pkg::KEY_COUNT - 1));
            end else if (r < 65) begin
                r = $urandom_range(0, mrkm_pkg::KEY_COUNT - 1);
                send_keyword(r, $urandom_range(0, int'(mrkm_pkg::KEY_LEN[r]) - 1), 1'b1);
                send_line_end();
            end else if (r < 80) begin
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            end else if (r < 88) begin
                send_byte(mrkm_pkg::CHAR_NUL);
                send_response($urandom_range(0, mrkm_pkg::KEY_COUNT - 1));
            end else begin
                send_query();
            end
            if ($urandom_range(0, 3) == 0) begin
                send_query();
            end
        end

        i_valid <= 1'b0;
        wait (codes_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("modem_response_keyword_matcher_top_test passed");
        end else begin
            $display("modem_response_keyword_matcher_top_test failed");
        end
        $finish;
    end

endmodule
